FILE: rtl/core/wmtf_pkg.sv
// ----------------------------------------------------------------------------
// wmtf_pkg
// Shared constants and types for the windowed mean and trimmed mean filter.
// ----------------------------------------------------------------------------
package wmtf_pkg;

   localparam int WINDOW_DEPTH = 8;
   localparam int SAMPLE_WIDTH = 16;
   localparam int TRIM_DROP    = 2;

   localparam int SLOT_W = $clog2(WINDOW_DEPTH);
   localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W  = SAMPLE_WIDTH + $clog2(WINDOW_DEPTH);
   localparam int DCNT_W = $clog2(SUM_W + 1);

   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;

   localparam logic [ADDR_W-3:0] REG_TRIM_MODE = '0;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic signed [SUM_W-1:0]        sum_type;

endpackage

FILE: rtl/core/window_mean_trimmed_filter_unit.sv
// ----------------------------------------------------------------------------
// window_mean_trimmed_filter_unit
// Moving average over the last samples, with an optional trimmed mean.
// ----------------------------------------------------------------------------
// Each accepted item is one signed sample and yields one filtered item. The
// unit holds off new items while it works: it reads the slot being replaced,
// updates the ring store and running sum, then in trimmed mode with more than
// TRIM_DROP entries filled runs a min/max scan over the filled entries, and
// finally a restoring divider produces one quotient bit per cycle (SUM_W bits,
// 19 at the default depth) before the item is handed to the output. The
// hand-over waits while the previous item is still unread in the output
// register. A finished item waits in the output register, so the next sample
// is taken while it is unread.
module window_mean_trimmed_filter_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [wmtf_pkg::SAMPLE_WIDTH-1:0] req_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [wmtf_pkg::SAMPLE_WIDTH-1:0] rsp_filtered,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [wmtf_pkg::ADDR_W-1:0]       paddr,
   input  logic [wmtf_pkg::DATA_W-1:0]       pwdata,
   output logic [wmtf_pkg::DATA_W-1:0]       prdata,
   output logic                              pready
);

   localparam int SW = wmtf_pkg::SAMPLE_WIDTH;
   localparam int AW = wmtf_pkg::ADDR_W;
   localparam int SLW = wmtf_pkg::SLOT_W;
   localparam int CW = wmtf_pkg::CNT_W;
   localparam int MW = wmtf_pkg::SUM_W;
   localparam int DW = wmtf_pkg::DCNT_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_UPD  = 3'd1;
   localparam logic [2:0] ST_SCAN = 3'd2;
   localparam logic [2:0] ST_TRIM = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   wmtf_pkg::sample_type mem [wmtf_pkg::WINDOW_DEPTH];
   wmtf_pkg::sample_type mem_rd_ff;
   logic [SLW-1:0]       rd_addr;
   logic                 mem_we;

   logic [2:0]           state_ff, state_in;
   logic                 trim_ff, trim_in;
   logic [SLW-1:0]       slot_ff, slot_in;
   logic [CW-1:0]        count_ff, count_in;
   wmtf_pkg::sum_type    sum_ff, sum_in;
   wmtf_pkg::sample_type sample_ff, sample_in;
   logic [CW-1:0]        idx_ff, idx_in;
   wmtf_pkg::sample_type lo_ff, lo_in, hi_ff, hi_in;
   logic                 neg_ff, neg_in;
   logic [MW-1:0]        quo_ff, quo_in;
   logic [CW-1:0]        rem_ff, rem_in;
   logic [CW-1:0]        div_ff, div_in;
   logic [DW-1:0]        dcnt_ff, dcnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   wmtf_pkg::sample_type rsp_data_ff, rsp_data_in;

   wmtf_pkg::sample_type old_entry;
   wmtf_pkg::sum_type    sum_new;
   logic [CW-1:0]        count_new;
   logic signed [MW:0]   trim_wide;
   wmtf_pkg::sum_type    dividend;
   logic [CW:0]          trial;
   logic [MW-1:0]        quo_signed;
   logic                 load_div;
   logic                 cfg_write;
   logic                 req_accept;

   assign pready     = 1'b1;
   assign cfg_write  = psel && penable && pwrite;
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_data_ff;

   always_comb begin
      prdata = '0;
      if (paddr[AW-1:2] == wmtf_pkg::REG_TRIM_MODE) begin
         prdata[0] = trim_ff;
      end
   end

   assign old_entry = (count_ff == CW'(wmtf_pkg::WINDOW_DEPTH)) ? mem_rd_ff : '0;
   assign sum_new   = sum_ff - MW'(old_entry) + MW'(sample_ff);
   assign count_new = (count_ff == CW'(wmtf_pkg::WINDOW_DEPTH)) ? count_ff
                                                                : count_ff + 1'b1;
   assign trim_wide = (MW+1)'(sum_ff) - (MW+1)'(lo_ff) - (MW+1)'(hi_ff);
   assign trial     = {rem_ff, quo_ff[MW-1]};
   assign quo_signed = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

   always_comb begin
      rd_addr = slot_ff;
      if (state_ff == ST_SCAN) begin
         rd_addr = idx_ff[SLW-1:0];
      end
   end

   assign mem_we = (state_ff == ST_UPD);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[slot_ff] <= sample_ff;
      end
      mem_rd_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      trim_in      = trim_ff;
      slot_in      = slot_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      sample_in    = sample_ff;
      idx_in       = idx_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      neg_in       = neg_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      dcnt_in      = dcnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      load_div     = 1'b0;
      dividend     = sum_ff;

      if (cfg_write && paddr[AW-1:2] == wmtf_pkg::REG_TRIM_MODE) begin
         trim_in = pwdata[0];
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               sample_in = req_sample;
               state_in  = ST_UPD;
            end
         end
         ST_UPD: begin
            sum_in   = sum_new;
            count_in = count_new;
            slot_in  = (slot_ff == SLW'(wmtf_pkg::WINDOW_DEPTH - 1)) ? '0
                                                                     : slot_ff + 1'b1;
            if (trim_ff && count_new > CW'(wmtf_pkg::TRIM_DROP)) begin
               idx_in   = '0;
               state_in = ST_SCAN;
            end else begin
               dividend = sum_new;
               div_in   = count_new;
               load_div = 1'b1;
            end
         end
         ST_SCAN: begin
            if (idx_ff == CW'(1)) begin
               lo_in = mem_rd_ff;
               hi_in = mem_rd_ff;
            end else if (idx_ff != '0) begin
               if (mem_rd_ff < lo_ff) begin
                  lo_in = mem_rd_ff;
               end
               if (mem_rd_ff > hi_ff) begin
                  hi_in = mem_rd_ff;
               end
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == count_ff) begin
               state_in = ST_TRIM;
            end
         end
         ST_TRIM: begin
            dividend = trim_wide[MW-1:0];
            div_in   = count_ff - CW'(wmtf_pkg::TRIM_DROP);
            load_div = 1'b1;
         end
         ST_DIV: begin
            if (trial >= {1'b0, div_ff}) begin
               rem_in = CW'(trial - {1'b0, div_ff});
               quo_in = {quo_ff[MW-2:0], 1'b1};
            end else begin
               rem_in = trial[CW-1:0];
               quo_in = {quo_ff[MW-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff - 1'b1;
            if (dcnt_ff == DW'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = quo_signed[SW-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load_div) begin
         neg_in   = dividend[MW-1];
         quo_in   = dividend[MW-1] ? (~dividend + 1'b1) : dividend;
         rem_in   = '0;
         dcnt_in  = DW'(MW);
         state_in = ST_DIV;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         trim_ff      <= 1'b0;
         slot_ff      <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         trim_ff      <= trim_in;
         slot_ff      <= slot_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff   <= sample_in;
      idx_ff      <= idx_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      neg_ff      <= neg_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      dcnt_ff     <= dcnt_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: rtl/core/wmtf_checker.sv
// ----------------------------------------------------------------------------
// wmtf_checker
// Port-level checks for the windowed mean and trimmed mean filter.
// ----------------------------------------------------------------------------
module wmtf_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [wmtf_pkg::SAMPLE_WIDTH-1:0] rsp_filtered
);

   // A stalled item stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result item dropped while stalled");

   // A stalled item keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_filtered))
      else $error("result item changed while stalled");

   // The unit is busy right after it takes an item.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again before work finished");

   // A new result appears only at the end of work on an item.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result item appeared while the unit was idle");

endmodule

bind window_mean_trimmed_filter_unit wmtf_checker u_wmtf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_filtered (rsp_filtered)
);

FILE: tb/sv/window_mean_trimmed_filter_unit_tb.sv
// ----------------------------------------------------------------------------
// window_mean_trimmed_filter_unit_tb
// Self-checking testbench for the windowed mean and trimmed mean filter.
// ----------------------------------------------------------------------------
// Samples are sent over the request channel and every filtered item is
// compared with a running prediction of the eight-entry window, the running
// sum and the fill count. The trim mode register is written and read back
// through the register port while the unit is idle. Directed items cover a
// filling window in trimmed mode, ties on the extremes, the ring wrap and
// negative truncation. Random phases follow, with both modes and random
// gaps and stalls on both sides, and one long hold on the result side
// that fills the unit and stalls its input.
module window_mean_trimmed_filter_unit_tb;
   typedef wmtf_pkg::sample_type sample_type;

   typedef enum logic {MODE_MEAN = 1'b0, MODE_TRIMMED = 1'b1} filter_mode_type;

   localparam logic [wmtf_pkg::ADDR_W-3:0] REG_SPARE = 1'b1;
   localparam int SETTLE_CYCLES = 60;
   localparam int HOLD_CYCLES = 400;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [wmtf_pkg::SAMPLE_WIDTH-1:0] req_sample;
   logic rsp_valid;
   logic rsp_stall;
   logic [wmtf_pkg::SAMPLE_WIDTH-1:0] rsp_filtered;
   logic psel;
   logic penable;
   logic pwrite;
   logic [wmtf_pkg::ADDR_W-1:0] paddr;
   logic [wmtf_pkg::DATA_W-1:0] pwdata;
   logic [wmtf_pkg::DATA_W-1:0] prdata;
   logic pready;

   int window_ring [wmtf_pkg::WINDOW_DEPTH];
   int ring_slot;
   int window_fill;
   int window_total;
   filter_mode_type trim_on;

   sample_type pending_filtered [$];
   sample_type last_sample;
   int failures;
   bit gap_enable;
   bit stall_enable;
   bit hold_request;

   window_mean_trimmed_filter_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample(req_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_filtered(rsp_filtered),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #5 clock = ~clock;

   function automatic sample_type average_after(input sample_type s);
      int lo;
      int hi;
      int q;
      window_total = window_total - window_ring[ring_slot] + int'(s);
      window_ring[ring_slot] = s;
      if (window_fill < wmtf_pkg::WINDOW_DEPTH) begin
         window_fill++;
      end
      ring_slot = (ring_slot + 1) % wmtf_pkg::WINDOW_DEPTH;
      if (trim_on == MODE_TRIMMED && window_fill > wmtf_pkg::TRIM_DROP) begin
         lo = window_ring[0];
         hi = window_ring[0];
         for (int i = 1; i < window_fill; i++) begin
            if (window_ring[i] < lo) lo = window_ring[i];
            if (window_ring[i] > hi) hi = window_ring[i];
         end
         q = (window_total - lo - hi) / (window_fill - wmtf_pkg::TRIM_DROP);
      end else begin
         q = window_total / window_fill;
      end
      return sample_type'(q);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!gap_enable || r < 65) return 0;
      if (r < 95) return $urandom_range(1, 4);
      return $urandom_range(20, 60);
   endfunction

   function automatic sample_type pick_sample();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0, 1, 2, 3: begin
            return sample_type'($urandom);
         end
         4, 5: begin
            return sample_type'($urandom_range(0, 16) - 8);
         end
         6: begin
            return $urandom_range(0, 1) ? sample_type'(32767) : sample_type'(-32768);
         end
         7: begin
            return last_sample;
         end
         default: begin
            return $urandom_range(0, 1) ? sample_type'(32767 - $urandom_range(0, 3))
                                        : sample_type'(-32768 + $urandom_range(0, 3));
         end
      endcase
   endfunction

   // Each call starts and ends just after a falling edge.
   task automatic send_sample(input sample_type s);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_sample <= sample_type'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_filtered.push_back(average_after(s));
      last_sample = s;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_filtered.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_access(input logic [wmtf_pkg::ADDR_W-3:0] index,
                             input logic wr,
                             input logic [wmtf_pkg::DATA_W-1:0] value,
                             output logic [wmtf_pkg::DATA_W-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      data = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [wmtf_pkg::ADDR_W-3:0] index,
                            input logic [wmtf_pkg::DATA_W-1:0] value);
      logic [wmtf_pkg::DATA_W-1:0] unused;
      csr_access(index, 1'b1, value, unused);
      if (index == wmtf_pkg::REG_TRIM_MODE) begin
         trim_on = filter_mode_type'(value[0]);
      end
   endtask

   task automatic check_trim_mode();
      logic [wmtf_pkg::DATA_W-1:0] data;
      logic [wmtf_pkg::DATA_W-1:0] want;
      want = {{(wmtf_pkg::DATA_W-1){1'b0}}, trim_on};
      csr_access(wmtf_pkg::REG_TRIM_MODE, 1'b0, $urandom, data);
      if (data !== want) begin
         $display("%0t: trim_mode read mismatch, expected %0h, actual %0h", $time, want, data);
         failures++;
      end
   endtask

   task automatic set_mode(input filter_mode_type mode);
      csr_write(wmtf_pkg::REG_TRIM_MODE,
                {(wmtf_pkg::DATA_W-1)'($urandom_range(0, 32'h7fff_ffff)), mode});
   endtask

   always @(posedge clock) begin : result_check
      sample_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_filtered.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual %0d",
                     $time, $signed(rsp_filtered));
            failures++;
         end else begin
            want = pending_filtered.pop_front();
            if (rsp_filtered !== want) begin
               $display("%0t: filtered mismatch, expected %0d, actual %0d",
                        $time, want, $signed(rsp_filtered));
               failures++;
            end
         end
      end
   end

   initial begin : rsp_stall_driver
      int stall_run;
      int long_hold;
      int r;
      stall_run = 0;
      long_hold = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            long_hold = HOLD_CYCLES;
         end
         if (long_hold > 0) begin
            rsp_stall <= 1'b1;
            long_hold--;
         end else if (!stall_enable) begin
            rsp_stall <= 1'b0;
         end else if (stall_run > 0) begin
            rsp_stall <= 1'b1;
            stall_run--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               rsp_stall <= 1'b0;
            end else if (r < 97) begin
               rsp_stall <= 1'b1;
               stall_run = $urandom_range(0, 3);
            end else begin
               rsp_stall <= 1'b1;
               stall_run = $urandom_range(20, 80);
            end
         end
      end
   end

   task automatic test_register_access();
      check_trim_mode();
      csr_write(REG_SPARE, 32'hffff_ffff);
      check_trim_mode();
      csr_write(wmtf_pkg::REG_TRIM_MODE, 32'hffff_fffe);
      check_trim_mode();
      csr_write(wmtf_pkg::REG_TRIM_MODE, 32'h8000_0001);
      check_trim_mode();
   endtask

   // The window is empty only once, so the trimmed fill is the first test that sends samples.
   task automatic test_trimmed_fill();
      sample_type seq [10];
      seq = '{16'sh7fff, 16'sh8000, 16'sd5, 16'sd5, 16'sd5,
              -16'sd3, 16'sh8000, 16'sh7fff, 16'sd9, -16'sd9};
      set_mode(MODE_TRIMMED);
      gap_enable = 1'b1;
      stall_enable = 1'b1;
      foreach (seq[i]) send_sample(seq[i]);
      wait_idle();
   endtask

   task automatic test_mean_extremes();
      set_mode(MODE_MEAN);
      check_trim_mode();
      repeat (wmtf_pkg::WINDOW_DEPTH) send_sample(16'sh8000);
      send_sample(16'sd1);
      send_sample(-16'sd2);
      send_sample(16'sd7);
      wait_idle();
   endtask

   task automatic test_random_phases();
      int n;
      for (int phase = 0; phase < 12; phase++) begin
         set_mode(phase < 4 ? filter_mode_type'(phase[0])
                            : filter_mode_type'($urandom_range(0, 1)));
         check_trim_mode();
         gap_enable = (phase != 2) && ($urandom_range(0, 3) != 0);
         stall_enable = (phase != 2) && ($urandom_range(0, 3) != 0);
         n = $urandom_range(140, 180);
         repeat (n) send_sample(pick_sample());
         wait_idle();
      end
   endtask

   task automatic test_backpressure();
      set_mode(MODE_TRIMMED);
      gap_enable = 1'b0;
      stall_enable = 1'b1;
      hold_request = 1'b1;
      repeat (40) send_sample(pick_sample());
      wait_idle();
   endtask

   initial begin
      failures = 0;
      ring_slot = 0;
      window_fill = 0;
      window_total = 0;
      foreach (window_ring[i]) window_ring[i] = 0;
      trim_on = MODE_MEAN;
      last_sample = '0;
      gap_enable = 1'b0;
      stall_enable = 1'b0;
      hold_request = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_register_access();
      test_trimmed_fill();
      test_mean_extremes();
      test_random_phases();
      test_backpressure();

      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #15_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
